// ===== hw/rtl/rct_pkg.sv =====
`default_nettype none

package rct_pkg;

    // Timebase width and the fixed widths of the register and result fields
    localparam int TICK_BITS_DEF = 24;
    localparam int CFG_TICK_W    = 24;
    localparam int COUNT_W       = 8;
    localparam int SUM_W         = 32;
    localparam int MEAS_W        = 24;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [MEAS_W-1:0]  MEAS_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // Register reset values
    localparam logic [CFG_TICK_W-1:0] TIMEOUT_RST = 24'd500000;
    localparam logic [CFG_TICK_W-1:0] PAUSE_RST   = 24'd1000000;
    localparam logic [COUNT_W-1:0]    TARGET_RST  = 8'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd2;

    // Event codes reported with each result beat
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_MEASURE = 3'd2,
        EV_TIMEOUT = 3'd3,
        EV_SKIP    = 3'd4
    } event_t;

    typedef struct packed {
        logic [CFG_TICK_W-1:0] timeout_ticks;
        logic [CFG_TICK_W-1:0] pause_ticks;
        logic [COUNT_W-1:0]    target_count;
    } cfg_t;

    // One result item, finished flag in the top bit
    typedef struct packed {
        logic               finished;
        logic [SUM_W-1:0]   total_ticks;
        logic [COUNT_W-1:0] good_count;
        logic [MEAS_W-1:0]  measured_ticks;
        event_t             event_res;
        logic               relay_on;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rct_cfg.sv =====
`default_nettype none

module rct_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rct_pkg::CFG_W-1:0]     cfg_wdata,
    output rct_pkg::cfg_t                      cfg
);
    import rct_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.pause_ticks   <= PAUSE_RST;
            cfg_reg.target_count  <= TARGET_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wdata[CFG_TICK_W-1:0];
                REG_PAUSE:   cfg_reg.pause_ticks   <= cfg_wdata[CFG_TICK_W-1:0];
                REG_TARGET:  cfg_reg.target_count  <= cfg_wdata[COUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rct_core.sv =====
`default_nettype none

module rct_core
#(
    parameter int TICK_BITS = rct_pkg::TICK_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         tick,
    input  wire logic         contact_closed,
    input  wire logic         close_edge,
    input  rct_pkg::cfg_t     cfg,
    output rct_pkg::result_t  result,
    output logic              done
);
    import rct_pkg::*;

    localparam int CMP_W = (TICK_BITS > CFG_TICK_W) ? TICK_BITS : CFG_TICK_W;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    typedef enum logic [1:0] {
        PH_START,
        PH_WAIT,
        PH_PAUSE,
        PH_DONE
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 drive_reg, drive_next;

    logic [TICK_BITS-1:0] elapsed_inc;
    logic                 at_max;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic [MEAS_W-1:0]    meas_sat;
    logic [SUM_W:0]       sum_wide;
    logic [COUNT_W-1:0]   count_inc;
    logic [MEAS_W-1:0]    meas;
    event_t               ev;

    // Saturating tick count and its derived values
    assign at_max      = (elapsed_reg == TICK_MAX);
    assign elapsed_inc = at_max ? elapsed_reg : elapsed_reg + 1'b1;
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign meas_sat    = (elapsed_cmp > CMP_W'(MEAS_MAX)) ? MEAS_MAX
                                                          : MEAS_W'(elapsed_cmp);
    assign sum_wide    = {1'b0, sum_reg} + (SUM_W+1)'(meas_sat);
    assign count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Phase sequencing for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        drive_next   = drive_reg;
        ev           = EV_NONE;
        meas         = '0;
        unique case (phase_reg)
            PH_START:
            begin
                elapsed_next = '0;
                if (contact_closed)
                begin
                    phase_next = PH_PAUSE;
                    ev         = EV_SKIP;
                end
                else
                begin
                    drive_next = 1'b1;
                    phase_next = PH_WAIT;
                    ev         = EV_START;
                end
            end
            PH_WAIT:
            begin
                elapsed_next = elapsed_inc;
                if (close_edge)
                begin
                    meas         = meas_sat;
                    drive_next   = 1'b0;
                    count_next   = count_inc;
                    sum_next     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    elapsed_next = '0;
                    phase_next   = (count_inc >= cfg.target_count) ? PH_DONE : PH_PAUSE;
                    ev           = EV_MEASURE;
                end
                else if (elapsed_cmp >= CMP_W'(cfg.timeout_ticks) ||
                         elapsed_inc == TICK_MAX)
                begin
                    drive_next   = 1'b0;
                    elapsed_next = '0;
                    phase_next   = PH_PAUSE;
                    ev           = EV_TIMEOUT;
                end
            end
            PH_PAUSE:
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_cmp >= CMP_W'(cfg.pause_ticks) || elapsed_inc == TICK_MAX)
                begin
                    phase_next = PH_START;
                end
            end
            PH_DONE:
            begin
                drive_next = 1'b0;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Advance the state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            elapsed_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            drive_reg   <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            drive_reg   <= drive_next;
        end
    end

    // Result of this tick, taken from the state it leaves behind
    assign result.relay_on       = drive_next;
    assign result.event_res      = ev;
    assign result.measured_ticks = meas;
    assign result.good_count     = count_next;
    assign result.total_ticks    = sum_next;
    assign result.finished       = (phase_next == PH_DONE);

    assign done = (phase_reg == PH_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/rct_skid.sv =====
`default_nettype none

module rct_skid
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  rct_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rct_pkg::result_t out_data,
    output logic             skid_full
);
    import rct_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_take;

    assign out_take = out_valid_reg & out_ready;
    assign ready    = ~skid_valid_reg;

    // Control: output stage first, spill into the skid stage on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/relay_closing_time_tester.sv =====
// Relay closing-time tester: one timebase tick in, one status beat out.
// A result beat is registered in the output stage, or in the skid stage behind a stalled one.
// Throughput: one tick per cycle while tready is high; tready falls while the skid stage is full.
// The state update for a tick is a single pass of compare/add logic in the core.
// Reset (rst_n, asynchronous) clears phase, counters, total and relay drive and
// loads the register defaults; no clearing pass is needed.
`default_nettype none

module relay_closing_time_tester
#(
    parameter int TICK_BITS = rct_pkg::TICK_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rct_pkg::CFG_W-1:0]       cfg_wdata,
    // Tick stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] contact_closed, [1] close_edge, [7:2] zero
    input  wire logic [rct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Status stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] relay_on, [3:1] event_res, [27:4] measured_ticks, [35:28] good_count,
    // [67:36] total_ticks, [68] finished, [71:69] zero
    output logic [rct_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import rct_pkg::*;

    localparam int RES_W = $bits(result_t);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    tick;
    logic    done;
    logic    skid_full;

    assign tick = s_axis_tvalid & s_axis_tready;

    // Register bank
    rct_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Phase sequencer and accumulators
    rct_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .contact_closed (s_axis_tdata[0]),
        .close_edge     (s_axis_tdata[1]),
        .cfg            (cfg),
        .result         (core_result),
        .done           (done)
    );

    // Result register with skid stage
    rct_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .push_data (core_result),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result),
        .skid_full (skid_full)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-RES_W)'(0), out_result};

    // Skid stage only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> m_axis_tvalid)
        else $error("skid stage holds a beat while output stage is empty");

    // Done phase is final
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> done)
        else $error("tester left the done phase");

    // The output holds a valid beat in the cycle after every accepted tick
    a_tick_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> m_axis_tvalid)
        else $error("accepted tick produced no result beat");

    // The relay is never driven in a result that reports finished
    a_off_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result.finished) |-> !out_result.relay_on)
        else $error("relay driven after finish");

endmodule

`default_nettype wire

// ===== verif/relay_closing_time_tester_test.sv =====
`default_nettype none

module relay_closing_time_tester_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rct_pkg::*;

    // Predictor phases
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_WAIT  = 2'd1,
        PH_PAUSE = 2'd2,
        PH_DONE  = 2'd3
    } tester_phase_t;

    // One timebase tick as it sits in tdata, contact level in bit 0
    typedef struct packed {
        logic close_edge;
        logic contact_closed;
    } tick_t;

    localparam logic [CFG_TICK_W-1:0] TICKS_MAX    = '1;
    localparam logic [TICK_BITS_DEF-1:0] ELAPSED_MAX = '1;
    localparam int EDGE_BUDGET   = 220;
    localparam int TARGET_FLOOR  = 230;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ROUNDS = 15;
    localparam int ROUND_TICKS   = 100;

    logic clk;
    logic rst_n = 1'b0;

    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] contact_closed, [1] close_edge, [7:2] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] relay_on, [3:1] event_res, [27:4] measured_ticks, [35:28] good_count,
    // [67:36] total_ticks, [68] finished, [71:69] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    relay_closing_time_tester uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Ticks waiting to be sent and status beats still owed by the block
    tick_t   pending_ticks[$];
    result_t expected_status[$];
    tick_t   offered_tick = '0;

    // Shadow of the tester state and its registers
    cfg_t              reg_shadow = '{TIMEOUT_RST, PAUSE_RST, TARGET_RST};
    tester_phase_t     phase_q    = PH_START;
    logic [TICK_BITS_DEF-1:0] elapsed_q = '0;
    logic [COUNT_W-1:0] good_q    = '0;
    logic [SUM_W-1:0]   total_q   = '0;
    logic               relay_q   = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_left   = 0;
    logic holdoff_go   = 1'b0;
    int edges_sent     = 0;
    int mismatches     = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Advance the tester by one tick and return the status it reports
    function automatic result_t step_tester(input tick_t t);
        result_t r;
        logic [SUM_W:0] sum_wide;
        r = '0;
        r.event_res = EV_NONE;
        case (phase_q)
            PH_START:
            begin
                elapsed_q = '0;
                if (t.contact_closed)
                begin
                    phase_q = PH_PAUSE;
                    r.event_res = EV_SKIP;
                end
                else
                begin
                    relay_q = 1'b1;
                    phase_q = PH_WAIT;
                    r.event_res = EV_START;
                end
            end
            PH_WAIT:
            begin
                if (elapsed_q != ELAPSED_MAX)
                    elapsed_q = elapsed_q + 1'b1;
                // closing edge wins over a timeout on the same tick
                if (t.close_edge)
                begin
                    r.measured_ticks = elapsed_q;
                    relay_q = 1'b0;
                    if (good_q != COUNT_MAX)
                        good_q = good_q + 1'b1;
                    sum_wide = {1'b0, total_q} + (SUM_W+1)'(elapsed_q);
                    total_q = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    elapsed_q = '0;
                    phase_q = (good_q >= reg_shadow.target_count) ? PH_DONE : PH_PAUSE;
                    r.event_res = EV_MEASURE;
                end
                else if (elapsed_q >= reg_shadow.timeout_ticks || elapsed_q == ELAPSED_MAX)
                begin
                    relay_q = 1'b0;
                    elapsed_q = '0;
                    phase_q = PH_PAUSE;
                    r.event_res = EV_TIMEOUT;
                end
            end
            PH_PAUSE:
            begin
                if (elapsed_q != ELAPSED_MAX)
                    elapsed_q = elapsed_q + 1'b1;
                if (elapsed_q >= reg_shadow.pause_ticks || elapsed_q == ELAPSED_MAX)
                    phase_q = PH_START;
            end
            default:
                relay_q = 1'b0;
        endcase
        r.relay_on    = relay_q;
        r.good_count  = good_q;
        r.total_ticks = total_q;
        r.finished    = (phase_q == PH_DONE);
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Driver: predict on every accepted beat, then offer the next tick or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_status.push_back(step_tester(offered_tick));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_tick  <= pending_ticks[0];
                    s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, pending_ticks[0]};
                    s_axis_tvalid <= 1'b1;
                    pending_ticks.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_go)
            holdoff_left <= HOLD_CYCLES;
    end

    // Monitor: compare each status beat with the oldest prediction
    always @(posedge clk)
    begin : status_check
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = result_t'(m_axis_tdata[68:0]);
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected status beat, expected none, got %0h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("relay_on", 32'(want.relay_on), 32'(seen.relay_on));
                    check_field("event_res", 32'(want.event_res), 32'(seen.event_res));
                    check_field("measured_ticks", 32'(want.measured_ticks),
                                32'(seen.measured_ticks));
                    check_field("good_count", 32'(want.good_count), 32'(seen.good_count));
                    check_field("total_ticks", want.total_ticks, seen.total_ticks);
                    check_field("finished", 32'(want.finished), 32'(seen.finished));
                end
            end
            m_axis_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_tick(input logic closed, input logic close_edge);
        tick_t t;
        t.contact_closed = closed;
        t.close_edge     = close_edge;
        pending_ticks.push_back(t);
    endtask

    // Wait until every tick is sent and every status beat has come back
    task automatic settle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TIMEOUT: reg_shadow.timeout_ticks = val;
            REG_PAUSE:   reg_shadow.pause_ticks   = val;
            REG_TARGET:  reg_shadow.target_count  = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    function automatic logic [CFG_W-1:0] pick_short(input int top);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return 1;
        return CFG_W'($urandom_range(2, top));
    endfunction

    initial
    begin : stimulus
        logic contact_level;
        logic rising;
        logic want_edge;
        int   run_left;
        int   round_no;
        int   n;
        contact_level = 1'b0;
        rising        = 1'b0;
        run_left      = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: skip on closed contact, edge ignored in pause, pause end,
        // closure on the first waiting tick, timeout, edge and timeout together
        write_reg(REG_TIMEOUT, 3);
        write_reg(REG_PAUSE, 2);
        write_reg(REG_TARGET, 255);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        settle();

        // Directed: zero timeout and zero pause
        write_reg(REG_TIMEOUT, 0);
        write_reg(REG_PAUSE, 0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        settle();

        // Random rounds: mostly realistic contact bounce-free runs, some noise
        for (round_no = 0; round_no < RANDOM_ROUNDS; round_no++)
        begin
            case (round_no % 4)
                0: set_pace(0, 0);
                1: set_pace(62, 0);
                2: set_pace(0, 62);
                default: set_pace(8, 8);
            endcase
            if (round_no == 0)
            begin
                write_reg(REG_TIMEOUT, 1);
                write_reg(REG_PAUSE, 1);
                write_reg(REG_TARGET, 255);
            end
            else if (round_no == 1)
            begin
                write_reg(REG_TIMEOUT, TICKS_MAX);
                write_reg(REG_PAUSE, 0);
                write_reg(REG_TARGET, CFG_W'($urandom_range(TARGET_FLOOR, 255)));
            end
            else
            begin
                write_reg(REG_TIMEOUT, ($urandom_range(0, 9) == 0) ? TICKS_MAX : pick_short(12));
                write_reg(REG_PAUSE, pick_short(30));
                write_reg(REG_TARGET, CFG_W'($urandom_range(TARGET_FLOOR, 255)));
            end

            // Hold the receiver off so the block fills and stalls its input
            if (round_no == 4)
            begin
                @(posedge clk);
                holdoff_go <= 1'b1;
                @(posedge clk);
                holdoff_go <= 1'b0;
            end

            for (n = 0; n < ROUND_TICKS; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    if (run_left == 0)
                    begin
                        contact_level = !contact_level;
                        run_left = contact_level ? $urandom_range(1, 6) : $urandom_range(1, 15);
                        rising = contact_level;
                    end
                    want_edge = rising;
                    rising = 1'b0;
                    run_left--;
                    queue_tick(contact_level, want_edge && edges_sent < EDGE_BUDGET);
                end
                else
                begin
                    want_edge = 1'($urandom_range(0, 1));
                    queue_tick(1'($urandom_range(0, 1)), want_edge && edges_sent < EDGE_BUDGET);
                end
                if (pending_ticks[$].close_edge)
                    edges_sent++;
            end
            settle();
        end

        // Final: bring the tester into its wait, then open the registers wide
        set_pace(0, 0);
        while (phase_q != PH_WAIT)
        begin
            queue_tick(1'b0, 1'b0);
            settle();
        end
        write_reg(REG_TIMEOUT, TICKS_MAX);
        write_reg(REG_PAUSE, TICKS_MAX);
        write_reg(REG_TARGET, 1);
        repeat (8) queue_tick(1'($urandom_range(0, 1)), 1'b0);
        queue_tick(1'b1, 1'b1);
        // Done phase ignores everything
        repeat (10) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        settle();
        repeat (10) @(posedge clk);

        if (expected_status.size() != 0)
        begin
            $display("%0t: %0d status beats never arrived", $time, expected_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
